// File: hdl/cooked_line_editor_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cooked line editor
// Shared property wrappers used by the assertion sections of the RTL.
// ----------------------------------------------------------------------------
`ifndef COOKED_LINE_EDITOR_UNIT_DEFINES_SVH
`define COOKED_LINE_EDITOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/cle_pkg.sv
// ----------------------------------------------------------------------------
// Cooked line editor package
// Character codes, state encodings and the control/status bundles shared
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package cle_pkg;

    localparam int NL_W = 32;
    localparam logic [NL_W-1:0] NL_MAX = '1;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_C        = 8'h43;
    localparam logic [7:0] CH_D        = 8'h44;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_DEL      = 8'h7F;
    localparam logic [7:0] CH_ZERO     = 8'h00;

    typedef enum logic [1:0] {
        ESC_NORMAL  = 2'd0,
        ESC_SEEN    = 2'd1,
        ESC_BRACKET = 2'd2
    } esc_state_t;

    typedef enum logic [1:0] {
        KIND_ECHO  = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_EMPTY = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_ECHO,
        ACT_ERASE,
        ACT_RIGHT,
        ACT_EMPTY,
        ACT_READ
    } act_t;

    typedef enum logic [2:0] {
        SRC_ECHO,
        SRC_BS,
        SRC_SPACE,
        SRC_MEM,
        SRC_ZERO
    } src_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ECHO,
        ST_ERASE_BS1,
        ST_ERASE_SP,
        ST_ERASE_BS2,
        ST_MEM_ECHO,
        ST_EMPTY,
        ST_RD_FETCH,
        ST_RD_EMIT
    } state_t;

    typedef struct packed {
        logic  load;
        logic  apply;
        logic  emit;
        src_t  src;
        kind_t kind;
        logic  last;
        logic  rd_fetch;
        logic  rd_step;
        logic  rd_finish;
    } ctrl_cmd_t;

    typedef struct packed {
        act_t act;
        logic out_free;
        logic rd_last;
    } dp_status_t;

endpackage

// File: hdl/cle_in_if.sv
// ----------------------------------------------------------------------------
// Input channel interface
// Carries one received byte or one read request per word.
// ----------------------------------------------------------------------------
interface cle_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;
    logic [6:0] read_max;

    modport source (output valid, output command, output rx_byte, output read_max,
                    input ready);
    modport sink   (input valid, input command, input rx_byte, input read_max,
                    output ready);
endinterface

// File: hdl/cle_out_if.sv
// ----------------------------------------------------------------------------
// Output channel interface
// Carries one echo, read data or status word per transfer.
// ----------------------------------------------------------------------------
interface cle_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output kind, output out_byte, output last,
                    input ready);
    modport sink   (input valid, input kind, input out_byte, input last,
                    output ready);
endinterface

// File: hdl/cooked_line_editor_unit.sv
// ----------------------------------------------------------------------------
// A received byte is accepted, decoded, then followed by its echo words, if any.
// A read is accepted, decoded and fetched, then emits bytes paced by the line store read port.
// Reset clears pointers, counts, escape state and output valid; the store is not cleared.
// ----------------------------------------------------------------------------
module cooked_line_editor_unit #(
    parameter int LINE_DEPTH = 1024,
    parameter int MAX_READ   = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    cle_in_if.sink      in_ch,
    cle_out_if.source   out_ch
);

    cle_pkg::ctrl_cmd_t  cmd;
    cle_pkg::dp_status_t status;
    logic                in_ready;

    assign in_ch.ready = in_ready;

    cle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    cle_dp #(
        .LINE_DEPTH (LINE_DEPTH),
        .MAX_READ   (MAX_READ)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_command  (in_ch.command),
        .in_rx_byte  (in_ch.rx_byte),
        .in_read_max (in_ch.read_max),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_kind    (out_ch.kind),
        .out_byte    (out_ch.out_byte),
        .out_last    (out_ch.last)
    );

endmodule

// File: hdl/cle_ctrl.sv
// ----------------------------------------------------------------------------
// Line editor controller
// Sequences word acceptance, state update, echo words and the read walk.
// ----------------------------------------------------------------------------
module cle_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  cle_pkg::dp_status_t   status,
    output cle_pkg::ctrl_cmd_t    cmd
);

    cle_pkg::state_t state_reg;
    cle_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cle_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg) inside
            cle_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = cle_pkg::ST_DECODE;
            end
            cle_pkg::ST_DECODE:
            begin
                unique case (status.act)
                    cle_pkg::ACT_ECHO:  state_next = cle_pkg::ST_ECHO;
                    cle_pkg::ACT_ERASE: state_next = cle_pkg::ST_ERASE_BS1;
                    cle_pkg::ACT_RIGHT: state_next = cle_pkg::ST_MEM_ECHO;
                    cle_pkg::ACT_EMPTY: state_next = cle_pkg::ST_EMPTY;
                    cle_pkg::ACT_READ:  state_next = cle_pkg::ST_RD_FETCH;
                    default:            state_next = cle_pkg::ST_IDLE;
                endcase
            end
            cle_pkg::ST_ERASE_BS1:
            begin
                if (status.out_free)
                    state_next = cle_pkg::ST_ERASE_SP;
            end
            cle_pkg::ST_ERASE_SP:
            begin
                if (status.out_free)
                    state_next = cle_pkg::ST_ERASE_BS2;
            end
            cle_pkg::ST_ECHO, cle_pkg::ST_ERASE_BS2, cle_pkg::ST_MEM_ECHO,
            cle_pkg::ST_EMPTY:
            begin
                if (status.out_free)
                    state_next = cle_pkg::ST_IDLE;
            end
            cle_pkg::ST_RD_FETCH:
            begin
                state_next = cle_pkg::ST_RD_EMIT;
            end
            cle_pkg::ST_RD_EMIT:
            begin
                if (status.out_free && status.rd_last)
                    state_next = cle_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cle_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        cmd.src  = cle_pkg::SRC_ECHO;
        cmd.kind = cle_pkg::KIND_ECHO;
        unique case (state_reg)
            cle_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            cle_pkg::ST_DECODE:
            begin
                cmd.apply = 1'b1;
            end
            cle_pkg::ST_ECHO:
            begin
                cmd.emit = status.out_free;
                cmd.last = 1'b1;
            end
            cle_pkg::ST_ERASE_BS1:
            begin
                cmd.emit = status.out_free;
                cmd.src  = cle_pkg::SRC_BS;
            end
            cle_pkg::ST_ERASE_SP:
            begin
                cmd.emit = status.out_free;
                cmd.src  = cle_pkg::SRC_SPACE;
            end
            cle_pkg::ST_ERASE_BS2:
            begin
                cmd.emit = status.out_free;
                cmd.src  = cle_pkg::SRC_BS;
                cmd.last = 1'b1;
            end
            cle_pkg::ST_MEM_ECHO:
            begin
                cmd.emit = status.out_free;
                cmd.src  = cle_pkg::SRC_MEM;
                cmd.last = 1'b1;
            end
            cle_pkg::ST_EMPTY:
            begin
                cmd.emit = status.out_free;
                cmd.src  = cle_pkg::SRC_ZERO;
                cmd.kind = cle_pkg::KIND_EMPTY;
                cmd.last = 1'b1;
            end
            cle_pkg::ST_RD_FETCH:
            begin
                cmd.rd_fetch = 1'b1;
            end
            cle_pkg::ST_RD_EMIT:
            begin
                cmd.emit      = status.out_free;
                cmd.src       = cle_pkg::SRC_MEM;
                cmd.kind      = cle_pkg::KIND_DATA;
                cmd.last      = status.rd_last;
                cmd.rd_step   = status.out_free;
                cmd.rd_fetch  = status.out_free && !status.rd_last;
                cmd.rd_finish = status.out_free && status.rd_last;
            end
            default:
            begin
                cmd.load = 1'b0;
            end
        endcase
    end

endmodule

// File: hdl/cle_dp.sv
// ----------------------------------------------------------------------------
// Line editor datapath
// Line store ring, edit pointers, escape state, newline count, read walk
// registers and the output word register.
// ----------------------------------------------------------------------------
`include "cooked_line_editor_unit_defines.svh"

module cle_dp #(
    parameter int LINE_DEPTH = 1024,
    parameter int MAX_READ   = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cle_pkg::ctrl_cmd_t   cmd,
    output cle_pkg::dp_status_t  status,
    input  logic                 in_command,
    input  logic [7:0]           in_rx_byte,
    input  logic [6:0]           in_read_max,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           out_kind,
    output logic [7:0]           out_byte,
    output logic                 out_last
);

    localparam int AW   = $clog2(LINE_DEPTH);
    localparam int LW   = $clog2(LINE_DEPTH + 1);
    localparam int RW   = $clog2(MAX_READ + 1);
    localparam int CMPW = (LW > 7) ? LW : 7;
    localparam int NW   = cle_pkg::NL_W;

    logic [7:0]             mem [LINE_DEPTH];
    logic [7:0]             mem_q_reg;

    logic [AW-1:0]          head_reg;
    logic [LW-1:0]          len_reg;
    logic [LW-1:0]          len_next;
    logic [LW-1:0]          cursor_reg;
    logic [LW-1:0]          cursor_next;
    cle_pkg::esc_state_t    esc_reg;
    cle_pkg::esc_state_t    esc_next;
    logic [cle_pkg::NL_W-1:0] nl_reg;
    logic [cle_pkg::NL_W-1:0] nl_next;

    logic [AW-1:0]          rd_ptr_reg;
    logic [AW-1:0]          rd_ptr_inc;
    logic [RW-1:0]          rd_cnt_reg;
    logic [RW-1:0]          rd_lim_reg;
    logic [RW-1:0]          rd_lim_next;
    logic [LW-1:0]          len_left;

    logic                   item_cmd_reg;
    logic [7:0]             byte_reg;
    logic [6:0]             max_reg;
    logic [7:0]             echo_reg;
    logic [7:0]             echo_next;

    logic                   out_valid_reg;
    cle_pkg::kind_t         out_kind_reg;
    logic [7:0]             out_byte_reg;
    logic                   out_last_reg;
    logic [7:0]             emit_byte;
    logic                   out_free;

    cle_pkg::act_t          act;
    logic [7:0]             c_map;
    logic [AW-1:0]          slot_cur;
    logic [AW-1:0]          slot_len;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [7:0]             wr_data;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [LW-1:0]          len_m1;
    logic [LW-1:0]          cur_dec;
    logic [6:0]             req_n;
    logic [CMPW-1:0]        req_x;
    logic [CMPW-1:0]        len_x;
    logic [CMPW-1:0]        take_x;

    function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] base,
                                                input logic [LW-1:0] pos);
        logic [LW:0] sum;
        sum = (LW+1)'(base) + (LW+1)'(pos);
        if (sum >= (LW+1)'(LINE_DEPTH))
            sum = sum - (LW+1)'(LINE_DEPTH);
        return sum[AW-1:0];
    endfunction

    assign slot_cur   = ring_slot(head_reg, cursor_reg);
    assign slot_len   = ring_slot(head_reg, len_reg);
    assign rd_ptr_inc = (rd_ptr_reg == AW'(LINE_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
    assign len_left   = len_reg - LW'(rd_cnt_reg) - LW'(1);
    assign len_m1     = len_reg - LW'(1);
    assign cur_dec    = (cursor_reg != '0) ? cursor_reg - LW'(1) : cursor_reg;
    assign c_map      = (byte_reg == cle_pkg::CH_CR) ? cle_pkg::CH_LF : byte_reg;

    always_comb
    begin
        req_n = (max_reg == 7'd0) ? 7'd1 : max_reg;
        if (req_n > 7'(MAX_READ))
            req_n = 7'(MAX_READ);
        req_x       = CMPW'(req_n);
        len_x       = CMPW'(len_reg);
        take_x      = (len_x < req_x) ? len_x : req_x;
        rd_lim_next = take_x[RW-1:0];
    end

    always_comb
    begin
        act         = cle_pkg::ACT_NONE;
        esc_next    = esc_reg;
        len_next    = len_reg;
        cursor_next = cursor_reg;
        nl_next     = nl_reg;
        wr_en       = 1'b0;
        wr_addr     = slot_cur;
        wr_data     = c_map;
        echo_next   = c_map;
        if (item_cmd_reg == cle_pkg::CMD_READ)
        begin
            if (nl_reg == '0 || len_reg == '0)
            begin
                act     = cle_pkg::ACT_EMPTY;
                nl_next = '0;
            end
            else
            begin
                act = cle_pkg::ACT_READ;
            end
        end
        else
        begin
            case (esc_reg)
                cle_pkg::ESC_SEEN:
                begin
                    esc_next = (byte_reg == cle_pkg::CH_LBRACKET) ?
                               cle_pkg::ESC_BRACKET : cle_pkg::ESC_NORMAL;
                end
                cle_pkg::ESC_BRACKET:
                begin
                    esc_next = cle_pkg::ESC_NORMAL;
                    if (byte_reg == cle_pkg::CH_D && cursor_reg != '0)
                    begin
                        act         = cle_pkg::ACT_ECHO;
                        cursor_next = cursor_reg - LW'(1);
                        echo_next   = cle_pkg::CH_BS;
                    end
                    else if (byte_reg == cle_pkg::CH_C && cursor_reg < len_reg)
                    begin
                        act         = cle_pkg::ACT_RIGHT;
                        cursor_next = cursor_reg + LW'(1);
                    end
                end
                default:
                begin
                    esc_next = cle_pkg::ESC_NORMAL;
                    if (c_map == cle_pkg::CH_ESC)
                    begin
                        esc_next = cle_pkg::ESC_SEEN;
                    end
                    else if (c_map == cle_pkg::CH_LF)
                    begin
                        if (len_reg != LW'(LINE_DEPTH))
                        begin
                            act         = cle_pkg::ACT_ECHO;
                            wr_en       = 1'b1;
                            wr_addr     = slot_len;
                            len_next    = len_reg + LW'(1);
                            cursor_next = len_reg + LW'(1);
                            nl_next     = (nl_reg == cle_pkg::NL_MAX) ? nl_reg
                                                                      : nl_reg + NW'(1);
                        end
                    end
                    else if (c_map == cle_pkg::CH_BS || c_map == cle_pkg::CH_DEL)
                    begin
                        act = cle_pkg::ACT_ERASE;
                        if (len_reg != '0)
                        begin
                            len_next    = len_m1;
                            cursor_next = (cur_dec > len_m1) ? len_m1 : cur_dec;
                        end
                    end
                    else if (c_map >= cle_pkg::CH_SPACE && c_map < cle_pkg::CH_DEL)
                    begin
                        if (cursor_reg < len_reg)
                        begin
                            act         = cle_pkg::ACT_ECHO;
                            wr_en       = 1'b1;
                            cursor_next = cursor_reg + LW'(1);
                        end
                        else if (len_reg < LW'(LINE_DEPTH - 1))
                        begin
                            act         = cle_pkg::ACT_ECHO;
                            wr_en       = 1'b1;
                            wr_addr     = slot_len;
                            len_next    = len_reg + LW'(1);
                            cursor_next = len_reg + LW'(1);
                        end
                    end
                end
            endcase
        end
    end

    assign rd_en   = (cmd.apply && act == cle_pkg::ACT_RIGHT) || cmd.rd_fetch;
    assign rd_addr = cmd.rd_fetch ? rd_ptr_reg : slot_cur;

    always_ff @(posedge clk)
    begin
        if (cmd.apply && wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            mem_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            len_reg       <= '0;
            cursor_reg    <= '0;
            esc_reg       <= cle_pkg::ESC_NORMAL;
            nl_reg        <= '0;
            rd_ptr_reg    <= '0;
            rd_cnt_reg    <= '0;
            rd_lim_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.apply)
            begin
                esc_reg    <= esc_next;
                len_reg    <= len_next;
                cursor_reg <= cursor_next;
                nl_reg     <= nl_next;
                if (act == cle_pkg::ACT_READ)
                begin
                    rd_ptr_reg <= head_reg;
                    rd_cnt_reg <= '0;
                    rd_lim_reg <= rd_lim_next;
                end
            end
            if (cmd.rd_fetch)
                rd_ptr_reg <= rd_ptr_inc;
            if (cmd.rd_step)
                rd_cnt_reg <= rd_cnt_reg + RW'(1);
            if (cmd.rd_finish)
            begin
                head_reg   <= rd_ptr_reg;
                len_reg    <= len_left;
                cursor_reg <= len_left;
                nl_reg     <= nl_reg - NW'(1);
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        case (cmd.src)
            cle_pkg::SRC_ECHO:  emit_byte = echo_reg;
            cle_pkg::SRC_BS:    emit_byte = cle_pkg::CH_BS;
            cle_pkg::SRC_SPACE: emit_byte = cle_pkg::CH_SPACE;
            cle_pkg::SRC_MEM:   emit_byte = mem_q_reg;
            default:            emit_byte = cle_pkg::CH_ZERO;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_cmd_reg <= in_command;
            byte_reg     <= in_rx_byte;
            max_reg      <= in_read_max;
        end
        if (cmd.apply)
            echo_reg <= echo_next;
        if (cmd.emit)
        begin
            out_kind_reg <= cmd.kind;
            out_byte_reg <= emit_byte;
            out_last_reg <= cmd.last;
        end
    end

    assign out_free        = !out_valid_reg || out_ready;
    assign status.act      = act;
    assign status.out_free = out_free;
    assign status.rd_last  = ((rd_cnt_reg + RW'(1)) == rd_lim_reg) ||
                             (mem_q_reg == cle_pkg::CH_LF);

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    `CLE_ASSERT_IMPL(a_cursor_in_line, clk, rst_n, 1'b1, cursor_reg <= len_reg, "cursor past end of line")
    `CLE_ASSERT_IMPL(a_len_in_range, clk, rst_n, 1'b1, len_reg <= LW'(LINE_DEPTH), "line length over depth")
    `CLE_ASSERT_IMPL(a_emit_when_free, clk, rst_n, cmd.emit, out_free, "word emitted over a pending word")
    `CLE_ASSERT_IMPL(a_read_in_limit, clk, rst_n, cmd.rd_step, rd_cnt_reg < rd_lim_reg, "read walk past its limit")
    `CLE_ASSERT_NEXT(a_finish_frees_line, clk, rst_n, cmd.rd_finish, cursor_reg == len_reg, "cursor not at end after read")

endmodule
